[rtl/bxds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxds_pkg
// Shared types, constants and helpers for the box average downscaler.
// ----------------------------------------------------------------------------
package bxds_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_HEIGHT     = 2048;
    localparam int GAIN_FRAC_BITS = 8;

    localparam int SIZE_W   = 12;  // size and gain registers
    localparam int POS_W    = 11;  // pixel positions
    localparam int SUM_W    = 19;  // 2048 * 255
    localparam int CNT_W    = 12;
    localparam int DIVD_W   = 20;  // dividend, holds count * 255
    localparam int QUOT_W   = 8;
    localparam int PROD_W   = SUM_W + SIZE_W;
    localparam int SCALED_W = PROD_W - GAIN_FRAC_BITS;
    localparam int LANES    = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [SIZE_W-1:0] MAX_W_C = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_C = SIZE_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_GAIN       = 3'd4,
        CFG_FLIP       = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pix_t;

    typedef struct packed {
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic [7:0]       alpha_out;
        logic             last_pixel;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_RSTART,
        S_RDIV,
        S_MERGE,
        S_MUL,
        S_VSTART,
        S_VDIV,
        S_FIN,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic load_px;
        logic accum;
        logic rd_start;
        logic v_start;
        logic div_step;
        logic merge;
        logic mul;
        logic copy_res;
        logic fin_res;
        logic advance;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic upscale;
        logic equal;
        logic row_done;
        logic vemit;
        logic div_last;
        logic out_free;
    } status_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] mx);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > mx)
            r = mx;
        else
            r = v;
        return r;
    endfunction

endpackage

[rtl/box_average_downscaler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downscaler_top
// Area average RGBA downscaler with gain and vertical flip.
// ----------------------------------------------------------------------------
// Source pixels come in raster order and are handled one request at a time.
// A pixel that closes no horizontal group passes through idle and evaluate;
// one that closes a horizontal group adds one restoring divide, 8 steps,
// for the row average plus column memory read and merge; one that also
// closes a vertical group adds the gain multiply, a second 8-step divide,
// finish and push, plus any wait for the output register to drain. Equal
// sizes copy each pixel through idle, evaluate and push, plus the same wait.
// The finished result sits in an output register, so a new pixel is taken
// while it waits. Configuration writes restart the frame and are to be made
// only while the block is idle. The column sums live in a 2048 x 76 bit
// memory.
// ----------------------------------------------------------------------------
module box_average_downscaler_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // source pixel request
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bxds_pkg::pix_t                  in_data,
    // result request
    output logic                            out_valid,
    input  logic                            out_ready,
    output bxds_pkg::res_t                  out_data,
    // register writes
    input  logic                            cfg_we,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bxds_pkg::SIZE_W-1:0]     cfg_data
);
    import bxds_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: steps one pixel through accumulate, divide, scale, push
    bxds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // all arithmetic, counters, column memory and the output register
    bxds_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/bxds_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxds_div
// Restoring divider, one quotient bit per step, quotient known below 256.
// ----------------------------------------------------------------------------
module bxds_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          step,
    input  logic [bxds_pkg::DIVD_W-1:0]   dividend,
    input  logic [bxds_pkg::CNT_W-1:0]    divisor,
    output logic [bxds_pkg::QUOT_W-1:0]   quot,
    output logic                          last
);
    import bxds_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] dsr_reg, dsr_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              ge;

    assign ge = rem_reg >= dsr_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = DIVD_W'({divisor, {(QUOT_W-1){1'b0}}});
            quot_next = '0;
            cnt_next  = STEP_W'(QUOT_W - 1);
        end
        else if (step)
        begin
            rem_next  = ge ? (rem_reg - dsr_reg) : rem_reg;
            dsr_next  = dsr_reg >> 1;
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign last = (cnt_reg == '0);

endmodule

[rtl/bxds_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxds_ctrl
// Sequencer: one request at a time through accumulate, divide, scale, push.
// ----------------------------------------------------------------------------
module bxds_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bxds_pkg::status_t status,
    output bxds_pkg::cmd_t    cmd
);
    import bxds_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_EVAL;
            S_EVAL:
            begin
                if (status.upscale)
                    state_next = S_IDLE;
                else if (status.equal)
                    state_next = S_PUSH;
                else if (status.row_done)
                    state_next = S_RSTART;
                else
                    state_next = S_IDLE;
            end
            S_RSTART: state_next = S_RDIV;
            S_RDIV:   if (status.div_last) state_next = S_MERGE;
            S_MERGE:  state_next = status.vemit ? S_MUL : S_IDLE;
            S_MUL:    state_next = S_VSTART;
            S_VSTART: state_next = S_VDIV;
            S_VDIV:   if (status.div_last) state_next = S_FIN;
            S_FIN:    state_next = S_PUSH;
            S_PUSH:   if (status.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_px = in_valid;
            end
            S_EVAL:
            begin
                if (status.upscale)
                    cmd.advance = 1'b1;
                else if (status.equal)
                begin
                    cmd.copy_res = 1'b1;
                    cmd.advance  = 1'b1;
                end
                else
                begin
                    cmd.accum   = 1'b1;
                    cmd.advance = !status.row_done;
                end
            end
            S_RSTART: cmd.rd_start = 1'b1;
            S_RDIV:   cmd.div_step = 1'b1;
            S_MERGE:
            begin
                cmd.merge   = 1'b1;
                cmd.advance = !status.vemit;
            end
            S_MUL:    cmd.mul = 1'b1;
            S_VSTART: cmd.v_start = 1'b1;
            S_VDIV:   cmd.div_step = 1'b1;
            S_FIN:
            begin
                cmd.fin_res = 1'b1;
                cmd.advance = 1'b1;
            end
            S_PUSH:   cmd.push = status.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

[rtl/bxds_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxds_datapath
// Registers, position counters, column sum memory, dividers and output stage.
// ----------------------------------------------------------------------------
module bxds_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bxds_pkg::pix_t                    in_data,
    input  logic                              cfg_we,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bxds_pkg::SIZE_W-1:0]       cfg_data,
    input  bxds_pkg::cmd_t                    cmd,
    output bxds_pkg::status_t                 status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bxds_pkg::res_t                    out_data
);
    import bxds_pkg::*;

    // configuration, sizes stored already clamped
    logic [SIZE_W-1:0] sw_reg, sh_reg, dw_reg, dh_reg, gain_reg;
    logic              flip_reg;
    logic              restart;

    // frame position
    logic [POS_W-1:0]  src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [POS_W-1:0]  dst_col_reg, dst_col_next, dst_row_reg, dst_row_next;
    logic [SIZE_W-1:0] row_phase_reg, row_phase_next, col_phase_reg, col_phase_next;
    logic [CNT_W-1:0]  row_count_reg, row_count_next, col_count_reg, col_count_next;
    logic [LANES-1:0][SUM_W-1:0] row_sums_reg, row_sums_next;

    pix_t                        px_reg;
    logic [LANES-1:0][7:0]       px_lane;
    logic [LANES-1:0][SUM_W-1:0] sum_reg, merged;
    logic [LANES-1:0][SCALED_W-1:0] scaled_reg;
    logic [LANES-1:0][DIVD_W-1:0]   div_dividend;
    logic [LANES-1:0][QUOT_W-1:0]   quot;
    logic [LANES-1:0]               div_last;
    logic [CNT_W-1:0]  div_divisor, vcnt;
    logic [DIVD_W-1:0] cap;

    logic [LANES*SUM_W-1:0] mem [MAX_WIDTH];
    logic [LANES*SUM_W-1:0] mem_q;

    logic [POS_W-1:0]  res_x_reg, res_y_reg;
    logic [LANES-1:0][7:0] res_ch_reg;
    logic              res_last_reg;
    logic              out_valid_reg;
    res_t              out_data_reg;

    logic              col_wrap, row_wrap, frame_end, grp_done;
    logic [SIZE_W:0]   row_phase_sum, col_phase_sum;
    logic [SIZE_W-1:0] y_norm, y_flip;

    assign px_lane = {px_reg.red_in, px_reg.green_in, px_reg.blue_in, px_reg.alpha_in};

    assign col_wrap  = ({1'b0, src_col_reg} + SIZE_W'(1)) >= sw_reg;
    assign row_wrap  = ({1'b0, src_row_reg} + SIZE_W'(1)) >= sh_reg;
    assign frame_end = col_wrap && row_wrap;

    assign row_phase_sum = {1'b0, row_phase_reg} + {1'b0, dw_reg};
    assign col_phase_sum = {1'b0, col_phase_reg} + {1'b0, dh_reg};
    assign grp_done      = col_phase_sum >= {1'b0, sh_reg};

    assign status.upscale  = (dw_reg > sw_reg) || (dh_reg > sh_reg);
    assign status.equal    = (dw_reg == sw_reg) && (dh_reg == sh_reg);
    assign status.row_done = row_phase_sum >= {1'b0, sw_reg};
    assign status.vemit    = grp_done;
    assign status.div_last = div_last[0];
    assign status.out_free = !out_valid_reg || out_ready;

    // configuration writes
    always_comb
    begin
        unique case (cfg_index)
            CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH,
            CFG_DST_HEIGHT, CFG_GAIN, CFG_FLIP: restart = cfg_we;
            default:                            restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg   <= SIZE_W'(1);
            sh_reg   <= SIZE_W'(1);
            dw_reg   <= SIZE_W'(1);
            dh_reg   <= SIZE_W'(1);
            gain_reg <= SIZE_W'(1 << GAIN_FRAC_BITS);
            flip_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  sw_reg   <= clamp_size(cfg_data, MAX_W_C);
                CFG_SRC_HEIGHT: sh_reg   <= clamp_size(cfg_data, MAX_H_C);
                CFG_DST_WIDTH:  dw_reg   <= clamp_size(cfg_data, MAX_W_C);
                CFG_DST_HEIGHT: dh_reg   <= clamp_size(cfg_data, MAX_H_C);
                CFG_GAIN:       gain_reg <= cfg_data;
                CFG_FLIP:       flip_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // position counters and horizontal sums
    always_comb
    begin
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        dst_col_next   = dst_col_reg;
        dst_row_next   = dst_row_reg;
        row_phase_next = row_phase_reg;
        col_phase_next = col_phase_reg;
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        row_sums_next  = row_sums_reg;

        if (cmd.accum)
        begin
            for (int i = 0; i < LANES; i++)
                row_sums_next[i] = row_sums_reg[i] + SUM_W'(px_lane[i]);
            row_count_next = row_count_reg + CNT_W'(1);
            if (status.row_done)
                row_phase_next = SIZE_W'(row_phase_sum - {1'b0, sw_reg});
            else
                row_phase_next = row_phase_sum[SIZE_W-1:0];
        end

        if (cmd.merge)
        begin
            row_sums_next  = '0;
            row_count_next = '0;
            dst_col_next   = dst_col_reg + POS_W'(1);
        end

        if (cmd.advance)
        begin
            if (!col_wrap)
                src_col_next = src_col_reg + POS_W'(1);
            else
            begin
                src_col_next   = '0;
                row_phase_next = '0;
                row_count_next = '0;
                row_sums_next  = '0;
                dst_col_next   = '0;
                if (grp_done)
                begin
                    col_phase_next = SIZE_W'(col_phase_sum - {1'b0, sh_reg});
                    col_count_next = '0;
                    dst_row_next   = dst_row_reg + POS_W'(1);
                end
                else
                begin
                    col_phase_next = col_phase_sum[SIZE_W-1:0];
                    col_count_next = col_count_reg + CNT_W'(1);
                end
                if (!row_wrap)
                    src_row_next = src_row_reg + POS_W'(1);
                else
                begin
                    src_row_next   = '0;
                    col_phase_next = '0;
                    col_count_next = '0;
                    dst_row_next   = '0;
                end
            end
        end

        if (restart)
        begin
            src_col_next   = '0;
            src_row_next   = '0;
            dst_col_next   = '0;
            dst_row_next   = '0;
            row_phase_next = '0;
            col_phase_next = '0;
            row_count_next = '0;
            col_count_next = '0;
            row_sums_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            dst_col_reg   <= '0;
            dst_row_reg   <= '0;
            row_phase_reg <= '0;
            col_phase_reg <= '0;
            row_count_reg <= '0;
            col_count_reg <= '0;
            row_sums_reg  <= '0;
        end
        else
        begin
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            dst_col_reg   <= dst_col_next;
            dst_row_reg   <= dst_row_next;
            row_phase_reg <= row_phase_next;
            col_phase_reg <= col_phase_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            row_sums_reg  <= row_sums_next;
        end
    end

    // column sum memory, read at the row divide start, written at merge
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            merged[i] = SUM_W'(quot[i]) +
                ((col_count_reg != '0) ? mem_q[i*SUM_W +: SUM_W] : '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.merge)
            mem[dst_col_reg] <= merged;
        if (cmd.rd_start)
            mem_q <= mem[dst_col_reg];
    end

    // gain and cap
    assign vcnt = col_count_reg + CNT_W'(1);
    assign cap  = DIVD_W'({vcnt, 8'd0}) - DIVD_W'(vcnt);

    always_comb
    begin
        div_divisor = cmd.v_start ? vcnt : row_count_reg;
        for (int i = 0; i < LANES; i++)
        begin
            if (cmd.v_start)
                div_dividend[i] = (scaled_reg[i] > SCALED_W'(cap)) ? cap
                                  : DIVD_W'(scaled_reg[i]);
            else
                div_dividend[i] = DIVD_W'(row_sums_reg[i]);
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        bxds_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (cmd.rd_start || cmd.v_start),
            .step     (cmd.div_step),
            .dividend (div_dividend[g]),
            .divisor  (div_divisor),
            .quot     (quot[g]),
            .last     (div_last[g])
        );
    end

    assign y_norm = flip_reg ? (dh_reg - SIZE_W'(1) - {1'b0, dst_row_reg})
                             : {1'b0, dst_row_reg};
    assign y_flip = flip_reg ? (sh_reg - SIZE_W'(1) - {1'b0, src_row_reg})
                             : {1'b0, src_row_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_px)
            px_reg <= in_data;
        if (cmd.merge)
        begin
            sum_reg   <= merged;
            res_x_reg <= dst_col_reg;
            res_y_reg <= y_norm[POS_W-1:0];
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < LANES; i++)
                scaled_reg[i] <= SCALED_W'((PROD_W'(sum_reg[i]) * PROD_W'(gain_reg))
                                           >> GAIN_FRAC_BITS);
        end
        if (cmd.copy_res)
        begin
            res_x_reg    <= src_col_reg;
            res_y_reg    <= y_flip[POS_W-1:0];
            res_ch_reg   <= px_lane;
            res_last_reg <= frame_end;
        end
        if (cmd.fin_res)
        begin
            res_ch_reg   <= quot;
            res_last_reg <= frame_end;
        end
        if (cmd.push)
        begin
            out_data_reg.out_x      <= res_x_reg;
            out_data_reg.out_y      <= res_y_reg;
            out_data_reg.red_out    <= res_ch_reg[3];
            out_data_reg.green_out  <= res_ch_reg[2];
            out_data_reg.blue_out   <= res_ch_reg[1];
            out_data_reg.alpha_out  <= res_ch_reg[0];
            out_data_reg.last_pixel <= res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("push into a full output register");

    a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> (row_count_reg != '0))
        else $error("row average with empty pixel group");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, src_col_reg} < sw_reg)
        else $error("source column beyond source width");

    a_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !(cmd.rd_start || cmd.v_start))
        else $error("divider start and step together");

endmodule

[bench/tb_box_average_downscaler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_average_downscaler_top
// Self-checking bench for the box average downscaler.
// ----------------------------------------------------------------------------
// A queue-fed driver offers RGBA pixels frame by frame. A cycle-free model of
// the area average (row groups, column groups, gain, clip, flip, equal-size
// copy, upscale drop) predicts each destination pixel. The monitor compares
// every result request against the oldest prediction. Registers are only
// rewritten once the block has drained.
// ----------------------------------------------------------------------------
module tb_box_average_downscaler_top;
    import bxds_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    pix_t                 in_data;
    logic                 out_valid;
    logic                 out_ready;
    res_t                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    box_average_downscaler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Stimulus and checking state
    // ------------------------------------------------------------------
    pix_t pending_pixels[$];
    res_t expected_pixels[$];
    int   mismatches;
    int   accepted_pixels;
    int   idle_pct;     // sender gap chance per cycle, percent
    int   stall_pct;    // receiver stall chance per cycle, percent
    bit   hold_off;     // long receiver stall for the back-pressure test
    bit   in_fire;      // input request taken at last rising edge

    // ------------------------------------------------------------------
    // Downscale model: registers as written, frame counters, column store
    // ------------------------------------------------------------------
    int unsigned reg_src_w, reg_src_h, reg_dst_w, reg_dst_h, reg_gain, reg_flip;
    int unsigned m_src_col, m_src_row, m_row_phase, m_row_count;
    int unsigned m_row_sum[LANES];
    int unsigned m_dst_col, m_col_phase, m_col_count, m_dst_row;
    int unsigned m_col_sum[LANES][MAX_WIDTH];

    function automatic void restart_frame();
        m_src_col = 0;
        m_src_row = 0;
        m_row_phase = 0;
        m_row_count = 0;
        for (int c = 0; c < LANES; c++)
            m_row_sum[c] = 0;
        m_dst_col = 0;
        m_col_phase = 0;
        m_col_count = 0;
        m_dst_row = 0;
    endfunction

    function automatic int unsigned size_of(int unsigned v, int unsigned mx);
        if (v == 0)
            return 1;
        return (v > mx) ? mx : v;
    endfunction

    // Step source position; 1 when the frame's last pixel went by
    function automatic bit step_position(int unsigned sw, int unsigned sh, int unsigned dh);
        if (m_src_col + 1 < sw)
        begin
            m_src_col++;
            return 1'b0;
        end
        m_src_col = 0;
        m_row_phase = 0;
        m_row_count = 0;
        for (int c = 0; c < LANES; c++)
            m_row_sum[c] = 0;
        m_dst_col = 0;
        m_col_count++;
        m_col_phase += dh;
        if (m_col_phase >= sh)
        begin
            m_col_phase -= sh;
            m_col_count = 0;
            m_dst_row++;
        end
        if (m_src_row + 1 < sh)
        begin
            m_src_row++;
            return 1'b0;
        end
        restart_frame();
        return 1'b1;
    endfunction

    function automatic void write_model_reg(cfg_idx_t idx, int unsigned val);
        case (idx)
            CFG_SRC_WIDTH:  reg_src_w = val & 12'hFFF;
            CFG_SRC_HEIGHT: reg_src_h = val & 12'hFFF;
            CFG_DST_WIDTH:  reg_dst_w = val & 12'hFFF;
            CFG_DST_HEIGHT: reg_dst_h = val & 12'hFFF;
            CFG_GAIN:       reg_gain  = val & 12'hFFF;
            CFG_FLIP:       reg_flip  = val & 1;
            default:        ;
        endcase
        restart_frame();
    endfunction

    // Predict the result (if any) caused by one accepted source pixel
    function automatic void predict_downscale(pix_t p);
        int unsigned sw, sh, dw, dh, x, y, avg, sum, cnt;
        int unsigned px[LANES];
        longint unsigned scaled, cap;
        int unsigned lane_out[LANES];
        bit vemit, last, emit;
        res_t r;
        sw = size_of(reg_src_w, MAX_WIDTH);
        sh = size_of(reg_src_h, MAX_HEIGHT);
        dw = size_of(reg_dst_w, MAX_WIDTH);
        dh = size_of(reg_dst_h, MAX_HEIGHT);
        px[0] = p.red_in;
        px[1] = p.green_in;
        px[2] = p.blue_in;
        px[3] = p.alpha_in;
        emit = 1'b0;
        if (dw > sw || dh > sh)
        begin
            // upscale request: position moves, nothing comes out
            void'(step_position(sw, sh, dh));
            return;
        end
        if (dw == sw && dh == sh)
        begin
            x = m_src_col;
            y = reg_flip ? (sh - 1 - m_src_row) : m_src_row;
            last = step_position(sw, sh, dh);
            for (int c = 0; c < LANES; c++)
                lane_out[c] = px[c];
            emit = 1'b1;
        end
        else
        begin
            vemit = (m_col_phase + dh) >= sh;
            x = m_dst_col;
            y = reg_flip ? (dh - 1 - m_dst_row) : m_dst_row;
            for (int c = 0; c < LANES; c++)
                m_row_sum[c] += px[c];
            m_row_count++;
            m_row_phase += dw;
            if (m_row_phase >= sw)
            begin
                m_row_phase -= sw;
                cnt = m_col_count + 1;
                for (int c = 0; c < LANES; c++)
                begin
                    avg = (m_row_sum[c] / m_row_count) & 8'hFF;
                    sum = avg;
                    if (m_dst_col < MAX_WIDTH)
                    begin
                        if (m_col_count != 0)
                            sum += m_col_sum[c][m_dst_col];
                        m_col_sum[c][m_dst_col] = sum;
                    end
                    // gain, clip to count*255, then divide by count
                    scaled = (longint'(sum) * longint'(reg_gain)) >> GAIN_FRAC_BITS;
                    cap = longint'(cnt) * 255;
                    if (scaled > cap)
                        scaled = cap;
                    lane_out[c] = int'(scaled / cnt) & 8'hFF;
                    m_row_sum[c] = 0;
                end
                m_row_count = 0;
                m_dst_col++;
                emit = vemit;
            end
            last = step_position(sw, sh, dh);
        end
        if (emit)
        begin
            r.out_x      = POS_W'(x);
            r.out_y      = POS_W'(y);
            r.red_out    = lane_out[0][7:0];
            r.green_out  = lane_out[1][7:0];
            r.blue_out   = lane_out[2][7:0];
            r.alpha_out  = lane_out[3][7:0];
            r.last_pixel = last;
            expected_pixels.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: take requests at the rising edge, drive at the falling one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_fire = in_valid && in_ready;
        if (in_fire)
        begin
            predict_downscale(in_data);
            accepted_pixels++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_fire))
        begin
            // previous request gone (or none): offer the next or go idle
            if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                in_data  <= pending_pixels.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d", out_data.out_x, out_data.out_y);
            end
            else if (out_data !== expected_pixels[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp x=%0d y=%0d rgba=%h_%h_%h_%h last=%b | got x=%0d y=%0d rgba=%h_%h_%h_%h last=%b",
                             expected_pixels[0].out_x, expected_pixels[0].out_y,
                             expected_pixels[0].red_out, expected_pixels[0].green_out,
                             expected_pixels[0].blue_out, expected_pixels[0].alpha_out,
                             expected_pixels[0].last_pixel,
                             out_data.out_x, out_data.out_y, out_data.red_out,
                             out_data.green_out, out_data.blue_out, out_data.alpha_out,
                             out_data.last_pixel);
                void'(expected_pixels.pop_front());
            end
            else
                void'(expected_pixels.pop_front());
        end
    end

    // Long receiver hold-off while the sender keeps offering pixels
    initial
    begin
        hold_off = 1'b0;
        wait (accepted_pixels >= 300);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // Run limit
    initial
    begin
        #30ms;
        $display("[box_average_downscaler_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    int phase_no;

    // Wait until drained, plus margin for a pixel that closes no result
    task automatic drain();
        while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= SIZE_W'(val);
        write_model_reg(idx, val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Rotate idle pattern: none, sender gaps, receiver stalls, both
    task automatic next_idle_mode();
        case (phase_no % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 56; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 56; end
            default: begin idle_pct = 6; stall_pct = 6; end
        endcase
        phase_no++;
    endtask

    task automatic setup_frame(int unsigned sw, int unsigned sh, int unsigned dw,
                               int unsigned dh, int unsigned g, int unsigned fl);
        drain();
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_FLIP, fl);
        next_idle_mode();
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_pixels.push_back(pix_t'($urandom));
    endtask

    initial
    begin
        int unsigned sw, sh, dw, dh, g, n;
        int sel;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SRC_WIDTH;
        cfg_data = '0;
        mismatches = 0;
        accepted_pixels = 0;
        phase_no = 0;
        idle_pct = 0;
        stall_pct = 0;
        in_fire = 1'b0;
        reg_src_w = 1;
        reg_src_h = 1;
        reg_dst_w = 1;
        reg_dst_h = 1;
        reg_gain = 256;
        reg_flip = 0;
        restart_frame();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset sizes 1x1: straight copy, channel extremes
        pending_pixels.push_back(32'h0000_0000);
        pending_pixels.push_back(32'hFFFF_FFFF);
        pending_pixels.push_back(32'hAA55_AA55);
        pending_pixels.push_back(32'h55AA_55AA);
        // Gain of zero
        setup_frame(4, 2, 2, 1, 0, 0);
        pending_pixels.push_back(32'hFFFF_FFFF);
        queue_random(7);
        // Equal sizes with flip, gain ignored
        setup_frame(3, 2, 3, 2, 4095, 1);
        queue_random(6);
        // Upscale request: nothing comes out
        setup_frame(2, 2, 3, 2, 256, 0);
        queue_random(4);
        // Uneven groups, max gain (clipped), flip
        setup_frame(3, 3, 2, 2, 4095, 1);
        for (int i = 0; i < 9; i++)
            pending_pixels.push_back(32'hFFFF_FFFF);

        // Oversize width saturates to 2048 and zero height becomes 1, so this
        // is a 2048 x 1 straight copy; part of the row is sent
        setup_frame(4095, 0, 2048, 1, 256, 0);
        queue_random(100);

        // Random frames, mostly small and well formed
        while (accepted_pixels < 850)
        begin
            sw = $urandom_range(1, 12);
            sh = $urandom_range(1, 6);
            dw = $urandom_range(1, sw);
            dh = $urandom_range(1, sh);
            sel = $urandom_range(99);
            case ($urandom_range(5))
                0: g = 0;
                1: g = 4095;
                2: g = 256;
                default: g = $urandom_range(4095);
            endcase
            if (sel < 8)
                dw = sw + $urandom_range(1, 3);     // upscale
            else if (sel < 14)
                begin dw = sw; dh = sh; end          // copy
            else if (sel < 18)
                dh = 0;                              // zero clamps to 1
            setup_frame(sw, sh, dw, dh, g, $urandom_range(1));
            n = sw * sh * $urandom_range(1, 2);
            if ($urandom_range(9) == 0)
                n = $urandom_range(1, sw * sh);      // cut short, next write restarts
            queue_random(n);
            if (hold_off)
                wait (!hold_off);
        end

        drain();
        if (mismatches == 0)
            $display("[box_average_downscaler_top] OK");
        else
            $display("[box_average_downscaler_top] ERROR");
        $finish;
    end

endmodule
